[design/sps_pkg.sv]
// sps_pkg: shared constants, codes and the half-step table for the stepper phase sequencer
// no dependencies
package sps_pkg;

   localparam int OP_W     = 2;
   localparam int STEPS_W  = 16;
   localparam int POS_W    = 16;
   localparam int LEFT_W   = 15;
   localparam int REV_W    = 15;
   localparam int COIL_W   = 4;
   localparam int PHASE_W  = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   typedef logic [OP_W-1:0]       op_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [COIL_W-1:0]     coil_type;
   typedef logic [PHASE_W-1:0]    phase_type;

   // operation codes
   localparam op_type OP_LOAD_MOVE = 2'd0;
   localparam op_type OP_STEP_TICK = 2'd1;
   localparam op_type OP_NORMALIZE = 2'd2;
   localparam op_type OP_UNUSED    = 2'd3;

   // configuration register indexes
   localparam csr_idx_type CSR_DRIVE_MODE    = 2'd0;
   localparam csr_idx_type CSR_STEPS_PER_REV = 2'd1;

   localparam logic [REV_W-1:0]  REV_RESET  = 15'd400;
   localparam coil_type          COIL_OFF   = 4'hF;
   localparam logic [LEFT_W-1:0] LEFT_MAX   = 15'h7FFF;

   // half-step coil table, active high
   function automatic coil_type half_step(input phase_type idx);
      coil_type pat;
      unique case (idx)
         3'd0: pat = 4'h1;
         3'd1: pat = 4'h3;
         3'd2: pat = 4'h2;
         3'd3: pat = 4'h6;
         3'd4: pat = 4'h4;
         3'd5: pat = 4'hC;
         3'd6: pat = 4'h8;
         3'd7: pat = 4'h9;
         default: pat = 4'h0;
      endcase
      return pat;
   endfunction

endpackage

[design/stepper_phase_sequencer.sv]
// stepper_phase_sequencer: top level, half-step / pulse stepper controller
// depends on sps_pkg
//
// usage
//   request channel (req_*): one transaction per command: load move, step tick,
//   normalize position against a target. valid/ready handshake.
//   response channel (rsp_*): exactly one transaction per request, carrying the
//   coil nibble (active low), step pulse, direction, position, steps left and
//   move done after that command.
//   csr port: csr_wr_en with csr_index / csr_wdata writes drive_mode (index 0)
//   or steps_per_rev (index 1); other indexes are ignored.
// latency and throughput
//   a request accepted at one edge shows its response from the next cycle on;
//   one request per cycle is taken as long as the response is drained.
//   the rate is set by the single response register: the command logic runs
//   in the cycle of acceptance and state updates at the same edge.
// reset
//   synchronous, active high: coils off (all ones), position zero, no steps
//   left, forward, pulse mode, 400 steps per revolution, response empty.
// stalls
//   while rsp_ready is low with a response held, req_ready is low; a request
//   is taken in the same cycle the held response leaves.
module stepper_phase_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  sps_pkg::op_type               req_operation,
   input  logic signed [sps_pkg::STEPS_W-1:0] req_move_steps,
   input  logic                          req_record_move,
   input  logic signed [sps_pkg::POS_W-1:0]   req_target_position,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sps_pkg::coil_type             rsp_coil_pattern,
   output logic                          rsp_step_pulse,
   output logic                          rsp_direction,
   output logic signed [sps_pkg::POS_W-1:0]   rsp_position,
   output logic [sps_pkg::LEFT_W-1:0]    rsp_steps_left,
   output logic                          rsp_move_done,
   // configuration port
   input  logic                          csr_wr_en,
   input  sps_pkg::csr_idx_type          csr_index,
   input  logic [sps_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sps_pkg::*;

   // configuration registers
   logic              drive_mode_ff, drive_mode_in;
   logic [REV_W-1:0]  rev_ff, rev_in;

   // motor state
   phase_type               phase_ff, phase_in;
   logic                    dir_ff, dir_in;
   logic signed [POS_W-1:0] pos_ff, pos_in;
   logic [LEFT_W-1:0]       left_ff, left_in;
   logic                    rec_ff, rec_in;
   coil_type                coil_ff, coil_in;

   // response register
   logic valid_ff, valid_in;
   logic pulse_ff, pulse_in;

   logic accept;

   // normalize datapath
   logic signed [POS_W+2:0] now_x, tgt_x, rev_x, half_x, diff, diff_sub;
   logic signed [POS_W+2:0] norm_x;
   logic signed [STEPS_W:0] neg_steps;

   // response register frees itself when drained
   assign req_ready = !valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // csr writes
   always_comb begin
      drive_mode_in = drive_mode_ff;
      rev_in        = rev_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DRIVE_MODE:    drive_mode_in = csr_wdata[0];
            CSR_STEPS_PER_REV: rev_in        = csr_wdata[REV_W-1:0];
            default: ;
         endcase
      end
   end

   // normalize: the two compares are formed in parallel from one difference
   always_comb begin
      now_x    = (POS_W+3)'(pos_ff);
      tgt_x    = (POS_W+3)'(req_target_position);
      rev_x    = (POS_W+3)'($signed({1'b0, rev_ff}));
      half_x   = (POS_W+3)'($signed({2'b00, rev_ff[REV_W-1:1]}));
      diff     = now_x - tgt_x;
      diff_sub = diff - rev_x;
      priority if (diff > half_x) begin
         // after taking one turn off, adding it back restores the original
         norm_x = (diff_sub < -half_x) ? now_x : now_x - rev_x;
      end else if (diff < -half_x) begin
         norm_x = now_x + rev_x;
      end else begin
         norm_x = now_x;
      end
   end

   assign neg_steps = -(STEPS_W+1)'(req_move_steps);

   // command logic
   always_comb begin
      phase_in = phase_ff;
      dir_in   = dir_ff;
      pos_in   = pos_ff;
      left_in  = left_ff;
      rec_in   = rec_ff;
      coil_in  = coil_ff;
      pulse_in = pulse_ff;
      valid_in = valid_ff && !rsp_ready;
      if (accept) begin
         valid_in = 1'b1;
         pulse_in = 1'b0;
         unique case (req_operation)
            OP_LOAD_MOVE: begin
               rec_in = req_record_move;
               priority if (req_move_steps > 0) begin
                  dir_in  = 1'b0;
                  left_in = req_move_steps[LEFT_W-1:0];
               end else if (req_move_steps < 0) begin
                  dir_in  = 1'b1;
                  // the most negative count saturates
                  left_in = neg_steps[STEPS_W-1] ? LEFT_MAX : neg_steps[LEFT_W-1:0];
               end else begin
                  left_in = '0;
               end
            end
            OP_STEP_TICK: begin
               if (left_ff != '0) begin
                  if (drive_mode_ff) begin
                     phase_in = dir_ff ? phase_ff - 3'd1 : phase_ff + 3'd1;
                     coil_in  = ~half_step(phase_in);
                  end else begin
                     pulse_in = 1'b1;
                  end
                  left_in = left_ff - 1'b1;
                  if (rec_ff) begin
                     pos_in = dir_ff ? pos_ff - 16'sd1 : pos_ff + 16'sd1;
                  end
               end
            end
            OP_NORMALIZE: pos_in = norm_x[POS_W-1:0];
            OP_UNUSED: ;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_mode_ff <= 1'b0;
         rev_ff        <= REV_RESET;
         phase_ff      <= '0;
         dir_ff        <= 1'b0;
         pos_ff        <= '0;
         left_ff       <= '0;
         rec_ff        <= 1'b0;
         coil_ff       <= COIL_OFF;
         valid_ff      <= 1'b0;
         pulse_ff      <= 1'b0;
      end else begin
         drive_mode_ff <= drive_mode_in;
         rev_ff        <= rev_in;
         phase_ff      <= phase_in;
         dir_ff        <= dir_in;
         pos_ff        <= pos_in;
         left_ff       <= left_in;
         rec_ff        <= rec_in;
         coil_ff       <= coil_in;
         valid_ff      <= valid_in;
         pulse_ff      <= pulse_in;
      end
   end

   // the state registers are the response payload
   assign rsp_valid        = valid_ff;
   assign rsp_coil_pattern = coil_ff;
   assign rsp_step_pulse   = pulse_ff;
   assign rsp_direction    = dir_ff;
   assign rsp_position     = pos_ff;
   assign rsp_steps_left   = left_ff;
   assign rsp_move_done    = (left_ff == '0);

endmodule

[design/sps_checker.sv]
// sps_checker: port-level assertions for stepper_phase_sequencer, bound to the top level
// depends on sps_pkg
module sps_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_step_pulse,
   input logic [sps_pkg::LEFT_W-1:0]    rsp_steps_left,
   input logic                          rsp_move_done
);
   import sps_pkg::*;

   // a held response stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // an empty response slot never blocks a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty response slot");

   // every accepted request produces a response in the next cycle
   a_one_response: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted transaction produced no response");

   // move done tracks the step counter
   a_done_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_move_done == (rsp_steps_left == '0)))
      else $error("move_done inconsistent with steps_left");

   // a pulse means a step was consumed, so the counter cannot be at its top
   a_pulse_consumed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_step_pulse |-> rsp_steps_left != LEFT_MAX)
      else $error("step pulse without a consumed step");

endmodule

bind stepper_phase_sequencer sps_checker u_sps_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_step_pulse (rsp_step_pulse),
   .rsp_steps_left (rsp_steps_left),
   .rsp_move_done  (rsp_move_done)
);
